### hdl/cmm_pkg.sv
// Shared types and constants for the complex matrix multiplier.
// Used by cmm_cmac, complex_matrix_multiply, cmm_checker and the testbench; depends on nothing else.
package cmm_pkg;

  localparam int unsigned MAX_DIM_DEF   = 4;
  localparam int unsigned MAX_ELEMS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 24;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_FLD_W = 2;
  localparam int unsigned DIM_REG_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MUL_SEL_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 3'd2;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // Partial product order within one inner step.
  localparam logic [MUL_SEL_W-1:0] MUL_AR_BR = 2'd0;
  localparam logic [MUL_SEL_W-1:0] MUL_AI_BI = 2'd1;
  localparam logic [MUL_SEL_W-1:0] MUL_AR_BI = 2'd2;
  localparam logic [MUL_SEL_W-1:0] MUL_AI_BR = 2'd3;

  typedef logic [2*DATA_W-1:0] cplx_word_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_FLD_W-1:0]     row;
    logic [IDX_FLD_W-1:0]     col;
    logic signed [DATA_W-1:0] in_re;
    logic signed [DATA_W-1:0] in_im;
  } in_word_t;

  typedef struct packed {
    logic [IDX_FLD_W-1:0]     out_row;
    logic [IDX_FLD_W-1:0]     out_col;
    logic signed [DATA_W-1:0] out_re;
    logic signed [DATA_W-1:0] out_im;
    logic                     saturated;
    logic                     last;
  } out_word_t;

  typedef struct packed {
    logic                 clear;
    logic                 mul_en;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 acc_en;
    logic                 rnd_en;
  } cmac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_DRAIN,
    ST_RND,
    ST_DONE
  } st_e;

endpackage

### hdl/complex_matrix_multiply.sv
// Top level of the complex matrix multiplier: configuration, A and B stores, sequencer.
// Depends on cmm_pkg and cmm_cmac.
//
// Load words write one complex Q8.24 element of A or B. A compute word produces
// a_rows*b_cols result words (each dimension clamped to 1..MAX_DIM) in row-major order,
// the final one flagged with last. Every product element goes through one shared 32x32
// multiplier: a store fetch and four partial products per inner step, then accumulate
// drain, rounding and output register load. Input is not accepted while a product is being
// computed; the last result word may still wait in the output register while the next word
// is accepted. Stores have no reset: compute only over
// elements already loaded.
module complex_matrix_multiply #(
  parameter int unsigned MAX_DIM   = cmm_pkg::MAX_DIM_DEF,
  parameter int unsigned MAX_ELEMS = cmm_pkg::MAX_ELEMS_DEF,
  parameter int unsigned FRAC_BITS = cmm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cmm_pkg::DIM_REG_W-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cmm_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cmm_pkg::out_word_t              out_word_o
);
  import cmm_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned IDX_W = $clog2(MAX_ELEMS);
  localparam int unsigned LIN_W = $clog2(MAX_DIM * MAX_DIM + MAX_ELEMS);

  function automatic logic [CW-1:0] dim_last(logic [DIM_REG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > MAX_DIM) begin
      r = CW'(MAX_DIM - 1);
    end else begin
      r = CW'(v - DIM_REG_W'(1));
    end
    return r;
  endfunction

  logic [DIM_REG_W-1:0] a_rows_q, inner_dim_q, b_cols_q;
  logic [CW-1:0]        i_last, j_last, k_last;
  st_e                  state_q, state_d;
  logic [CW-1:0]        i_q, j_q, k_q;
  logic [MUL_SEL_W-1:0] ph_q;
  logic                 in_fire, start, done_fire, last_elem, rd_en;
  logic [LIN_W-1:0]     ld_lin, a_lin, b_lin;
  logic                 ld_ok, a_we, b_we, a_oob, b_oob;
  cplx_word_t           a_mem [MAX_ELEMS];
  cplx_word_t           b_mem [MAX_ELEMS];
  cplx_word_t           a_rd_q, b_rd_q;
  logic                 a_oob_q, b_oob_q;
  cplx_word_t           a_word, b_word;
  cmac_ctrl_t           ctrl;
  logic signed [DATA_W-1:0] res_re, res_im;
  logic                 res_sat;
  logic                 out_valid_q;
  out_word_t            out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      b_cols_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_ROWS:    a_rows_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_B_COLS:    b_cols_q    <= cfg_data_i;
        default:       a_rows_q    <= a_rows_q;
      endcase
    end
  end

  assign i_last = dim_last(a_rows_q);
  assign k_last = dim_last(inner_dim_q);
  assign j_last = dim_last(b_cols_q);

  assign in_fire   = in_valid_i && in_ready_o;
  assign start     = in_fire && (in_word_i.kind == KIND_COMPUTE);
  assign last_elem = (i_q == i_last) && (j_q == j_last);
  assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign ld_lin = LIN_W'(in_word_i.row) * LIN_W'(MAX_DIM) + LIN_W'(in_word_i.col);
  assign ld_ok  = (LIN_W'(in_word_i.row) < LIN_W'(MAX_DIM)) &&
                  (LIN_W'(in_word_i.col) < LIN_W'(MAX_DIM)) &&
                  (ld_lin < LIN_W'(MAX_ELEMS));
  assign a_we   = in_fire && ld_ok && (in_word_i.kind == KIND_LOAD_A);
  assign b_we   = in_fire && ld_ok && (in_word_i.kind == KIND_LOAD_B);

  assign a_lin = LIN_W'(i_q) * LIN_W'(MAX_DIM) + LIN_W'(k_q);
  assign b_lin = LIN_W'(k_q) * LIN_W'(MAX_DIM) + LIN_W'(j_q);
  assign a_oob = a_lin >= LIN_W'(MAX_ELEMS);
  assign b_oob = b_lin >= LIN_W'(MAX_ELEMS);

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[ld_lin[IDX_W-1:0]] <= {in_word_i.in_im, in_word_i.in_re};
    end
    if (rd_en) begin
      a_rd_q  <= a_mem[a_lin[IDX_W-1:0]];
      a_oob_q <= a_oob;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[ld_lin[IDX_W-1:0]] <= {in_word_i.in_im, in_word_i.in_re};
    end
    if (rd_en) begin
      b_rd_q  <= b_mem[b_lin[IDX_W-1:0]];
      b_oob_q <= b_oob;
    end
  end

  assign a_word = a_oob_q ? '0 : a_rd_q;
  assign b_word = b_oob_q ? '0 : b_rd_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_MUL;
      ST_MUL: begin
        if (ph_q == MUL_AI_BR) begin
          state_d = (k_q == k_last) ? ST_DRAIN : ST_FETCH;
        end
      end
      ST_DRAIN: state_d = ST_RND;
      ST_RND:   state_d = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_d = last_elem ? ST_IDLE : ST_FETCH;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    rd_en        = (state_q == ST_FETCH);
    ctrl.clear   = (state_q == ST_FETCH) && (k_q == '0);
    ctrl.acc_en  = ((state_q == ST_FETCH) && (k_q != '0)) ||
                   ((state_q == ST_MUL) && (ph_q != MUL_AR_BR)) ||
                   (state_q == ST_DRAIN);
    ctrl.mul_en  = (state_q == ST_MUL);
    ctrl.mul_sel = ph_q;
    ctrl.rnd_en  = (state_q == ST_RND);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      ph_q    <= MUL_AR_BR;
    end else begin
      state_q <= state_d;
      if (start) begin
        i_q  <= '0;
        j_q  <= '0;
        k_q  <= '0;
        ph_q <= MUL_AR_BR;
      end
      if (state_q == ST_MUL) begin
        ph_q <= ph_q + MUL_SEL_W'(1);
        if (ph_q == MUL_AI_BR) begin
          k_q <= (k_q == k_last) ? '0 : k_q + CW'(1);
        end
      end
      if (done_fire && !last_elem) begin
        if (j_q == j_last) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
    end
  end

  cmm_cmac #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_cmac (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .a_word_i (a_word),
    .b_word_i (b_word),
    .res_re_o (res_re),
    .res_im_o (res_im),
    .sat_o    (res_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_word_q.out_row   <= IDX_FLD_W'(i_q);
      out_word_q.out_col   <= IDX_FLD_W'(j_q);
      out_word_q.out_re    <= res_re;
      out_word_q.out_im    <= res_im;
      out_word_q.saturated <= res_sat;
      out_word_q.last      <= last_elem;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (i_q <= i_last && j_q <= j_last && k_q <= k_last))
    else $error("product index outside configured dimensions");

  a_start_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_FETCH && i_q == '0 && j_q == '0 && k_q == '0))
    else $error("compute word did not start at the first element");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && last_elem) |=> (state_q == ST_IDLE && out_valid_o && out_word_o.last))
    else $error("final element did not return the sequencer to idle");

  a_phase_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (ph_q == MUL_AR_BR))
    else $error("inner step started at a nonzero partial product");

endmodule

### hdl/cmm_cmac.sv
// Shared complex multiply-accumulate unit: one 32x32 multiplier, exact accumulators,
// round-to-nearest and saturation back to Q8.24. Depends on cmm_pkg.
module cmm_cmac #(
  parameter int unsigned MAX_DIM   = cmm_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = cmm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  cmm_pkg::cmac_ctrl_t               ctrl_i,
  input  cmm_pkg::cplx_word_t               a_word_i,
  input  cmm_pkg::cplx_word_t               b_word_i,
  output logic signed [cmm_pkg::DATA_W-1:0] res_re_o,
  output logic signed [cmm_pkg::DATA_W-1:0] res_im_o,
  output logic                              sat_o
);
  import cmm_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned ACC_W  = PROD_W + 2 + $clog2(MAX_DIM);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

  logic signed [DATA_W-1:0] ar, ai, br, bi;
  logic signed [DATA_W-1:0] op_x, op_y;
  logic signed [PROD_W-1:0] prod_q;
  logic [MUL_SEL_W-1:0]     prod_sel_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0]  rnd_re_q, rnd_im_q;
  logic                     re_hi, re_lo, im_hi, im_lo;

  assign ar = a_word_i[DATA_W-1:0];
  assign ai = a_word_i[2*DATA_W-1:DATA_W];
  assign br = b_word_i[DATA_W-1:0];
  assign bi = b_word_i[2*DATA_W-1:DATA_W];

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_AR_BR: begin
        op_x = ar;
        op_y = br;
      end
      MUL_AI_BI: begin
        op_x = ai;
        op_y = bi;
      end
      MUL_AR_BI: begin
        op_x = ar;
        op_y = bi;
      end
      default: begin
        op_x = ai;
        op_y = br;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q     <= PROD_W'(op_x) * PROD_W'(op_y);
      prod_sel_q <= ctrl_i.mul_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.acc_en) begin
      case (prod_sel_q) inside
        MUL_AR_BR:            acc_re_q <= acc_re_q + ACC_W'(prod_q);
        MUL_AI_BI:            acc_re_q <= acc_re_q - ACC_W'(prod_q);
        MUL_AR_BI, MUL_AI_BR: acc_im_q <= acc_im_q + ACC_W'(prod_q);
        default:              acc_im_q <= acc_im_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rnd_en) begin
      rnd_re_q <= (acc_re_q + HALF) >>> FRAC_BITS;
      rnd_im_q <= (acc_im_q + HALF) >>> FRAC_BITS;
    end
  end

  assign re_hi = rnd_re_q > SAT_HI;
  assign re_lo = rnd_re_q < SAT_LO;
  assign im_hi = rnd_im_q > SAT_HI;
  assign im_lo = rnd_im_q < SAT_LO;

  assign res_re_o = re_hi ? SAT_HI[DATA_W-1:0] : (re_lo ? SAT_LO[DATA_W-1:0] : rnd_re_q[DATA_W-1:0]);
  assign res_im_o = im_hi ? SAT_HI[DATA_W-1:0] : (im_lo ? SAT_LO[DATA_W-1:0] : rnd_im_q[DATA_W-1:0]);
  assign sat_o    = re_hi | re_lo | im_hi | im_lo;

endmodule

### bench/cmm_checker.sv
// Checker for complex_matrix_multiply: mirrors the dimension registers and the A and B stores,
// predicts every product word on the output channel and compares it field by field.
// Depends on cmm_pkg.
module cmm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cmm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cmm_pkg::DIM_REG_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  cmm_pkg::in_word_t             in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  cmm_pkg::out_word_t            out_word_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   words_o,
  output int unsigned                   products_o,
  output int unsigned                   results_o,
  output int unsigned                   saturated_o
);
  import cmm_pkg::*;

  localparam int unsigned ACC_W = 72;
  localparam logic signed [ACC_W-1:0] Q_MAX    = 72'sd2147483647;
  localparam logic signed [ACC_W-1:0] Q_MIN    = -72'sd2147483648;
  localparam logic signed [ACC_W-1:0] HALF_LSB = 72'sd1 <<< (FRAC_BITS_DEF - 1);

  cplx_word_t           a_elems [MAX_ELEMS_DEF];
  cplx_word_t           b_elems [MAX_ELEMS_DEF];
  logic [DIM_REG_W-1:0] rows_cfg;
  logic [DIM_REG_W-1:0] inner_cfg;
  logic [DIM_REG_W-1:0] cols_cfg;
  out_word_t            product_queue [$];

  function automatic int unsigned dim_used(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(v);
  endfunction

  // Rounds to nearest with ties toward plus infinity, then clips; the top bit flags a clip.
  function automatic logic [DATA_W:0] round_clip(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    r = (acc + HALF_LSB) >>> FRAC_BITS_DEF;
    if (r > Q_MAX) return {1'b1, Q_MAX[DATA_W-1:0]};
    if (r < Q_MIN) return {1'b1, Q_MIN[DATA_W-1:0]};
    return {1'b0, r[DATA_W-1:0]};
  endfunction

  function automatic void multiply_stored();
    int unsigned              n;
    int unsigned              kd;
    int unsigned              p;
    logic signed [ACC_W-1:0]  acc_re;
    logic signed [ACC_W-1:0]  acc_im;
    logic signed [DATA_W-1:0] ar;
    logic signed [DATA_W-1:0] ai;
    logic signed [DATA_W-1:0] br;
    logic signed [DATA_W-1:0] bi;
    logic [DATA_W:0]          re_q;
    logic [DATA_W:0]          im_q;
    out_word_t                w;
    n  = dim_used(rows_cfg);
    kd = dim_used(inner_cfg);
    p  = dim_used(cols_cfg);
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = 0; j < p; j++) begin
        acc_re = '0;
        acc_im = '0;
        for (int unsigned k = 0; k < kd; k++) begin
          ar = a_elems[i*MAX_DIM_DEF+k][DATA_W-1:0];
          ai = a_elems[i*MAX_DIM_DEF+k][2*DATA_W-1:DATA_W];
          br = b_elems[k*MAX_DIM_DEF+j][DATA_W-1:0];
          bi = b_elems[k*MAX_DIM_DEF+j][2*DATA_W-1:DATA_W];
          acc_re = acc_re + ar * br - ai * bi;
          acc_im = acc_im + ar * bi + ai * br;
        end
        re_q = round_clip(acc_re);
        im_q = round_clip(acc_im);
        w.out_row   = IDX_FLD_W'(i);
        w.out_col   = IDX_FLD_W'(j);
        w.out_re    = re_q[DATA_W-1:0];
        w.out_im    = im_q[DATA_W-1:0];
        w.saturated = re_q[DATA_W] | im_q[DATA_W];
        w.last      = (i == n - 1) && (j == p - 1);
        product_queue.push_back(w);
      end
    end
  endfunction

  function automatic int unsigned field_diff(string name, logic [DATA_W-1:0] want,
                                             logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      rows_cfg     = DIM_RESET;
      inner_cfg    = DIM_RESET;
      cols_cfg     = DIM_RESET;
      product_queue.delete();
      fail_count_o = 0;
      words_o      = 0;
      products_o   = 0;
      results_o    = 0;
      saturated_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (product_queue.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, out_word_i);
          fail_count_o++;
        end else begin
          want = product_queue.pop_front();
          fail_count_o += field_diff("out_row", DATA_W'(want.out_row),
                                     DATA_W'(out_word_i.out_row));
          fail_count_o += field_diff("out_col", DATA_W'(want.out_col),
                                     DATA_W'(out_word_i.out_col));
          fail_count_o += field_diff("out_re", want.out_re, out_word_i.out_re);
          fail_count_o += field_diff("out_im", want.out_im, out_word_i.out_im);
          fail_count_o += field_diff("saturated", DATA_W'(want.saturated),
                                     DATA_W'(out_word_i.saturated));
          fail_count_o += field_diff("last", DATA_W'(want.last), DATA_W'(out_word_i.last));
          if (want.saturated) saturated_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_A_ROWS:    rows_cfg = cfg_data_i;
          CFG_INNER_DIM: inner_cfg = cfg_data_i;
          CFG_B_COLS:    cols_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        words_o++;
        case (in_word_i.kind)
          KIND_LOAD_A: begin
            a_elems[in_word_i.row*MAX_DIM_DEF+in_word_i.col] = {in_word_i.in_im, in_word_i.in_re};
          end
          KIND_LOAD_B: begin
            b_elems[in_word_i.row*MAX_DIM_DEF+in_word_i.col] = {in_word_i.in_im, in_word_i.in_re};
          end
          KIND_COMPUTE: begin
            products_o++;
            multiply_stored();
          end
          default: ;
        endcase
      end
    end
    pending_o = product_queue.size();
  end

endmodule

### bench/tb_complex_matrix_multiply.sv
// Testbench top for complex_matrix_multiply: resets the block, loads A and B, starts products
// under many dimension settings with random gaps on both channels, and gives the verdict.
// Depends on cmm_pkg, complex_matrix_multiply and cmm_checker.
module tb_complex_matrix_multiply;
  import cmm_pkg::*;

  localparam logic [1:0]           KIND_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;
  localparam int unsigned          WORD_TARGET     = 360;
  localparam int unsigned          SETTLE_CYCLES   = 30;
  localparam int unsigned          HOLD_OFF_CYCLES = 300;
  localparam int unsigned          DRAIN_LIMIT     = 20000;
  localparam logic [1:0]           NOISE_KINDS [3] = '{KIND_LOAD_A, KIND_LOAD_B, KIND_UNUSED};
  localparam logic [DIM_REG_W-1:0] PRESET_DIMS [6][3] = '{
    '{3'd1, 3'd1, 3'd1}, '{3'd4, 3'd4, 3'd4}, '{3'd0, 3'd7, 3'd0},
    '{3'd7, 3'd0, 3'd7}, '{3'd4, 3'd1, 3'd4}, '{3'd1, 3'd4, 3'd1}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DIM_REG_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_seen;
  int unsigned products_seen;
  int unsigned results_seen;
  int unsigned saturated_seen;

  logic                 a_loaded [MAX_ELEMS_DEF];
  logic                 b_loaded [MAX_ELEMS_DEF];
  logic [DIM_REG_W-1:0] dim_a = DIM_RESET;
  logic [DIM_REG_W-1:0] dim_k = DIM_RESET;
  logic [DIM_REG_W-1:0] dim_b = DIM_RESET;
  bit                   burst = 1'b0;
  bit                   hold_off_req = 1'b0;
  int unsigned          items_sent = 0;
  int unsigned          settings_done = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  complex_matrix_multiply dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  cmm_checker mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_o      (words_seen),
    .products_o   (products_seen),
    .results_o    (results_seen),
    .saturated_o  (saturated_seen)
  );

  function automatic int unsigned eff_dim(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [DIM_REG_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 3'd0;
      1: return 3'd7;
      default: return DIM_REG_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_item(logic [1:0] kind, int unsigned row, int unsigned col,
                           logic [DATA_W-1:0] re, logic [DATA_W-1:0] im);
    in_word_t    w;
    int unsigned gap;
    w.kind  = kind;
    w.row   = IDX_FLD_W'(row);
    w.col   = IDX_FLD_W'(col);
    w.in_re = re;
    w.in_im = im;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_LOAD_A) a_loaded[w.row*MAX_DIM_DEF+w.col] = 1'b1;
    if (kind == KIND_LOAD_B) b_loaded[w.row*MAX_DIM_DEF+w.col] = 1'b1;
    if (kind != KIND_UNUSED) items_sent++;
    gap = pick_gap(burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      send_item(NOISE_KINDS[$urandom_range(0, 2)], $urandom_range(0, 3), $urandom_range(0, 3),
                pick_part(), pick_part());
    end
  endtask

  // Loads what the current dimensions need, skipping some entries already loaded, then
  // starts one or two products.
  task automatic run_product();
    int unsigned n;
    int unsigned kd;
    int unsigned p;
    n  = eff_dim(dim_a);
    kd = eff_dim(dim_k);
    p  = eff_dim(dim_b);
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned k = 0; k < kd; k++) begin
        if (!a_loaded[i*MAX_DIM_DEF+k] || $urandom_range(0, 3) != 0) begin
          send_item(KIND_LOAD_A, i, k, pick_part(), pick_part());
        end
        maybe_noise();
      end
    end
    for (int unsigned k = 0; k < kd; k++) begin
      for (int unsigned j = 0; j < p; j++) begin
        if (!b_loaded[k*MAX_DIM_DEF+j] || $urandom_range(0, 3) != 0) begin
          send_item(KIND_LOAD_B, k, j, pick_part(), pick_part());
        end
        maybe_noise();
      end
    end
    send_item(KIND_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom(), $urandom());
    if ($urandom_range(0, 4) == 0) begin
      send_item(KIND_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom(), $urandom());
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_dims(logic [DIM_REG_W-1:0] ra, logic [DIM_REG_W-1:0] rk,
                          logic [DIM_REG_W-1:0] rb, bit spare);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_A_ROWS;
    cfg_data <= ra;
    @(negedge clk);
    cfg_idx  <= CFG_INNER_DIM;
    cfg_data <= rk;
    @(negedge clk);
    cfg_idx  <= CFG_B_COLS;
    cfg_data <= rb;
    @(negedge clk);
    if (spare) begin
      cfg_idx  <= CFG_SPARE;
      cfg_data <= DIM_REG_W'($urandom_range(0, 7));
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    dim_a = ra;
    dim_k = rk;
    dim_b = rb;
    settings_done++;
  endtask

  initial begin
    int unsigned stretch;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
        repeat (stretch) @(negedge clk);
        stretch = pick_gap(1'b0);
        if (stretch > 0) begin
          out_ready <= 1'b0;
          repeat (stretch) @(negedge clk);
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned waited;
    logic [DIM_REG_W-1:0] ra;
    logic [DIM_REG_W-1:0] rk;
    logic [DIM_REG_W-1:0] rb;
    for (int i = 0; i < MAX_ELEMS_DEF; i++) begin
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(KIND_LOAD_A, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(KIND_LOAD_A, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(KIND_LOAD_A, 1, 0, 32'h0100_0000, 32'hFF00_0000);
    send_item(KIND_LOAD_A, 1, 1, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_LOAD_B, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(KIND_LOAD_B, 0, 1, 32'h0080_0000, 32'h0000_0000);
    send_item(KIND_LOAD_B, 1, 0, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_LOAD_B, 1, 1, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(KIND_LOAD_A, 3, 3, $urandom(), $urandom());
    send_item(KIND_LOAD_B, 3, 3, $urandom(), $urandom());
    send_item(KIND_UNUSED, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_COMPUTE, 0, 0, 32'h0000_0000, 32'h0000_0000);
    wait_idle();
    set_dims(3'd1, 3'd1, 3'd1, 1'b0);
    // Half-LSB products: the positive tie rounds up, the negative one rounds toward zero.
    send_item(KIND_LOAD_A, 0, 0, 32'h0000_0001, 32'h0000_0000);
    send_item(KIND_LOAD_B, 0, 0, 32'h0080_0000, 32'hFF80_0000);
    send_item(KIND_COMPUTE, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_LOAD_A, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(KIND_COMPUTE, 0, 0, 32'h0000_0000, 32'h0000_0000);

    ph = 0;
    while (items_sent < WORD_TARGET) begin
      wait_idle();
      if (ph < 6) begin
        ra = PRESET_DIMS[ph][0];
        rk = PRESET_DIMS[ph][1];
        rb = PRESET_DIMS[ph][2];
      end else begin
        ra = rand_dim();
        rk = rand_dim();
        rb = rand_dim();
      end
      set_dims(ra, rk, rb, ph == 0);
      burst = ($urandom_range(0, 3) == 0);
      if (ph == 1) begin
        // Full-size products against a stalled output, so the block backs up into its input.
        burst = 1'b1;
        hold_off_req = 1'b1;
        while (hold_off_req) @(negedge clk);
        run_product();
        run_product();
      end else begin
        repeat ($urandom_range(1, 3)) run_product();
      end
      ph++;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0t: %0d expected result words never arrived", $time, pending);
    $display("Sent %0d input words with %0d products under %0d dimension settings.",
             words_seen, products_seen, settings_done);
    $display("Checked %0d result words, %0d of them saturated.", results_seen, saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
